FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
// Expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  localparam int MOD_W     = 31;
  localparam int BASE_W    = 63;
  localparam int RED_W     = 64;
  localparam int RED_BITS  = 2;
  localparam int RED_STEPS = RED_W / RED_BITS;
  localparam int CNT_W     = $clog2(RED_STEPS);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_BASE,
    ST_CHECK,
    ST_MUL_ACC,
    ST_RED_ACC,
    ST_MUL_SQ,
    ST_RED_SQ,
    ST_FINISH
  } mexp_state_t;

  typedef struct packed {
    logic load_item;
    logic mul_acc;
    logic mul_sq;
    logic red_step;
    logic wr_acc;
    logic wr_sq;
    logic shift_exp;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic red_last;
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
    logic out_free;
  } mexp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/mexp_ifs.sv
// Channel interfaces: request, response and modulus write.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mexp_req_if
  import mexp_pkg::*;
#(
  parameter int EXP_WIDTH = 63
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [BASE_W-1:0]    base_value;
  logic [EXP_WIDTH-1:0] exponent;

  modport source (output valid, op, base_value, exponent, input ready);
  modport sink   (input valid, op, base_value, exponent, output ready);
endinterface

interface mexp_rsp_if
  import mexp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

interface mexp_cfg_if
  import mexp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mexp_datapath.sv
// Datapath: modulus register, accumulator, running square, exponent shifter,
// one multiplier and a shared 2-bit-per-cycle reducer. Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int EXP_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mexp_cmd_t            cmd,
  output mexp_sts_t            sts,
  input  logic                 op,
  input  logic [BASE_W-1:0]    base_value,
  input  logic [EXP_WIDTH-1:0] exponent,
  mexp_cfg_if.sink             cfg,
  mexp_rsp_if.source           rsp
);

  localparam int EW = (EXP_WIDTH > MOD_W) ? EXP_WIDTH : MOD_W;

  logic [MOD_W-1:0]   modulus;
  logic [MOD_W-1:0]   acc;
  logic [MOD_W-1:0]   sq;
  logic [MOD_W-1:0]   rem;
  logic [MOD_W-1:0]   rem_next;
  logic [MOD_W-1:0]   result;
  logic               rsp_valid;
  logic [RED_W-1:0]   red_word;
  logic [CNT_W-1:0]   cnt;
  logic [EW-1:0]      ereg;
  logic [EW-1:0]      e_load;
  logic [MOD_W-1:0]   m_eff;
  logic [MOD_W:0]     m_ext;
  logic [MOD_W-1:0]   exp_inv;
  logic [MOD_W-1:0]   mul_a;
  logic [2*MOD_W-1:0] prod;

  assign m_eff   = (modulus == '0) ? MOD_W'(1) : modulus;
  assign m_ext   = {1'b0, m_eff};
  assign exp_inv = (m_eff >= MOD_W'(2)) ? (m_eff - MOD_W'(2)) : '0;
  assign e_load  = op ? EW'(exp_inv) : EW'(exponent);
  assign mul_a   = cmd.mul_acc ? acc : sq;
  assign prod    = mul_a * sq;

  always_comb begin
    logic [MOD_W:0]   t;
    logic [MOD_W-1:0] r;
    r = rem;
    for (int i = 0; i < RED_BITS; i++) begin
      t = {r, red_word[RED_W-1-i]};
      if (t >= m_ext) begin
        t = t - m_ext;
      end
      r = t[MOD_W-1:0];
    end
    rem_next = r;
  end

  always_comb begin
    sts.red_last      = (cnt == CNT_W'(RED_STEPS - 1));
    sts.exp_zero      = (ereg == '0);
    sts.exp_lsb       = ereg[0];
    sts.exp_rest_zero = (ereg[EW-1:1] == '0);
    sts.out_free      = !rsp_valid || rsp.ready;
  end

  assign cfg.ready  = 1'b1;
  assign rsp.valid  = rsp_valid;
  assign rsp.result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        modulus <= cfg.data;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      red_word <= RED_W'(base_value);
      rem      <= '0;
      cnt      <= '0;
      acc      <= MOD_W'(1);
      ereg     <= e_load;
    end else if (cmd.mul_acc || cmd.mul_sq) begin
      red_word <= RED_W'(prod);
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.red_step) begin
      red_word <= red_word << RED_BITS;
      rem      <= rem_next;
      cnt      <= cnt + CNT_W'(1);
    end
    if (cmd.wr_acc) begin
      acc <= rem_next;
    end
    if (cmd.wr_sq) begin
      sq <= rem_next;
    end
    if (cmd.shift_exp) begin
      ereg <= ereg >> 1;
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end

  `MEXP_ASSERT(a_load_init, cmd.load_item |=> (acc == MOD_W'(1) && cnt == '0), "load init")
  `MEXP_ASSERT(a_mul_clears, (cmd.mul_acc || cmd.mul_sq) |=> (cnt == '0 && rem == '0), "mul clr")
  `MEXP_ASSERT(a_out_load, cmd.out_load |=> (rsp_valid && result == $past(acc)), "out load")

endmodule

`default_nettype wire

FILE: rtl/core/mexp_controller.sv
// Controller: sequences base reduction and square-and-multiply steps.
// Depends on mexp_pkg; drives the datapath through mexp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mexp_controller
  import mexp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  mexp_sts_t sts,
  output mexp_cmd_t cmd
);

  mexp_state_t state;
  mexp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_RED_BASE;
        end
      end
      ST_RED_BASE: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          cmd.wr_sq  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.exp_zero) begin
          state_next = ST_FINISH;
        end else if (sts.exp_lsb) begin
          state_next = ST_MUL_ACC;
        end else begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        cmd.mul_acc = 1'b1;
        state_next  = ST_RED_ACC;
      end
      ST_RED_ACC: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          cmd.wr_acc = 1'b1;
          state_next = sts.exp_rest_zero ? ST_FINISH : ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = ST_RED_SQ;
      end
      ST_RED_SQ: begin
        cmd.red_step = 1'b1;
        if (sts.red_last) begin
          cmd.wr_sq     = 1'b1;
          cmd.shift_exp = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `MEXP_ASSERT(a_one_strobe, $onehot0({cmd.load_item, cmd.mul_acc, cmd.mul_sq, cmd.red_step, cmd.out_load}), "strobes")
  `MEXP_ASSERT(a_wr_at_end, (cmd.wr_acc || cmd.wr_sq) |-> (cmd.red_step && sts.red_last), "early write")
  `MEXP_ASSERT(a_out_idle, cmd.out_load |=> (state == ST_IDLE), "no idle after out")
  `MEXP_ASSERT_ALWAYS(a_ready_idle, req_ready |-> (state == ST_IDLE), "ready while busy")

endmodule

`default_nettype wire

FILE: rtl/core/modular_exponentiation_top.sv
// Channel   Dir  Handshake     Payload
// cfg       in   valid/ready   data (modulus, 31 b)
// req       in   valid/ready   op, base_value (63 b), exponent (EXP_WIDTH b)
// rsp       out  valid/ready   result (31 b)
// Order: load and reduce the base, then per exponent bit a check and a squaring, plus a
// multiply into the accumulator first when the bit is set (the top bit skips its squaring).
// One multiplier and one shared reducer (2 bits a cycle) do all the work; a new request
// is taken only in idle, once the current item is finished.
// Reset: modulus 1000000007, no result pending. A waiting result does not
// block the next request; a finished item holds until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int EXP_WIDTH = 63
) (
  input  logic       clk,
  input  logic       rst,
  mexp_cfg_if.sink   cfg,
  mexp_req_if.sink   req,
  mexp_rsp_if.source rsp
);

  mexp_cmd_t cmd;
  mexp_sts_t sts;
  logic      ctl_ready;

  assign req.ready = ctl_ready;

  mexp_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctl_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_datapath #(
    .EXP_WIDTH (EXP_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .op         (req.op),
    .base_value (req.base_value),
    .exponent   (req.exponent),
    .cfg        (cfg),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
